>>> sv/packet_timing_compliance_monitor_top_macros.svh
// assertion helpers
`ifndef PACKET_TIMING_COMPLIANCE_MONITOR_TOP_MACROS_SVH
`define PACKET_TIMING_COMPLIANCE_MONITOR_TOP_MACROS_SVH
`define PTCM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PTCM_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> sv/ptcm_pkg.sv
package ptcm_pkg;
   localparam int FILL_FRAC_BITS_DEF = 16;
   localparam int COUNTER_WIDTH_DEF = 32;
   localparam int SEQ_W = 16;
   localparam int ARR_W = 63;
   localparam int IVL_W = 30;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BURST = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LATENESS = 2'd3;
   localparam logic [IVL_W-1:0] RST_INTERVAL = 30'd166833;
   localparam logic [15:0] RST_CAPACITY = 16'd16;
   localparam logic [15:0] RST_BURST = 16'd8;
   localparam logic [31:0] RST_LATENESS = 32'd333666;

   typedef struct packed {
      logic [SEQ_W-1:0] seq_number;
      logic [ARR_W-1:0] arrival_time_ns;
   } req_type;

   typedef struct packed {
      logic old_or_duplicate;
      logic [31:0] buffer_fill;
      logic [31:0] peak_buffer_fill;
      logic [31:0] overflow_count;
      logic [15:0] burst_length;
      logic [15:0] longest_burst;
      logic signed [63:0] packet_lateness_ns;
      logic [62:0] worst_lateness_ns;
      logic [31:0] late_packets;
      logic [31:0] packet_count;
      logic compliant;
   } rsp_type;

   // classified request handed from front to back
   typedef struct packed {
      logic first;
      logic old;
      logic [31:0] ext;
      logic [ARR_W-1:0] arrival;
   } job_type;
endpackage

>>> sv/ptcm_req_if.sv
interface ptcm_req_if;
   import ptcm_pkg::*;
   logic valid;
   logic ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> sv/ptcm_rsp_if.sv
interface ptcm_rsp_if;
   import ptcm_pkg::*;
   logic valid;
   logic ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> sv/ptcm_front.sv
module ptcm_front (
   input logic clock,
   input logic reset,
   ptcm_req_if.sink req,
   output logic job_valid,
   input logic job_ready,
   output ptcm_pkg::job_type job
);
   import ptcm_pkg::*;
   logic started_ff;
   logic [31:0] newest_ff;
   logic [31:0] cand, ext;
   logic take;

   always_comb begin
      cand = {newest_ff[31:16], req.payload.seq_number};
      ext = cand;
      if (cand + 32'h8000 < newest_ff) begin
         ext = cand + 32'h10000;
      end else if (cand > newest_ff + 32'h8000 && cand >= 32'h10000) begin
         ext = cand - 32'h10000;
      end
   end

   assign req.ready = job_ready;
   assign take = req.valid & job_ready;
   assign job_valid = req.valid;
   assign job.first = !started_ff;
   assign job.old = started_ff && (ext <= newest_ff);
   assign job.ext = started_ff ? ext : {16'd0, req.payload.seq_number};
   assign job.arrival = req.payload.arrival_time_ns;

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         newest_ff <= '0;
      end else if (take) begin
         started_ff <= 1'b1;
         if (!job.old) begin
            newest_ff <= job.ext;
         end
      end
   end
endmodule

>>> sv/ptcm_queue.sv
module ptcm_queue (
   input logic clock,
   input logic reset,
   input logic in_valid,
   output logic in_ready,
   input ptcm_pkg::job_type in_job,
   output logic out_valid,
   input logic out_ready,
   output ptcm_pkg::job_type out_job
);
   import ptcm_pkg::*;
   job_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign in_ready = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_job = mem_ff[rp_ff];
   assign push = in_valid & in_ready;
   assign pop = out_valid & out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= in_job;
      end
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   `include "packet_timing_compliance_monitor_top_macros.svh"
   `PTCM_ASSERT(a_no_overrun, clock, reset, cnt_ff == 2'd2 |-> !push, "queue overrun")
   `PTCM_ASSERT(a_no_underrun, clock, reset, cnt_ff == 2'd0 |-> !pop, "queue underrun")
   `PTCM_ASSERT(a_count, clock, reset, push && !pop |=> cnt_ff == $past(cnt_ff) + 2'd1,
      "queue count")
endmodule

>>> sv/ptcm_back.sv
module ptcm_back #(
   parameter int FILL_FRAC_BITS = ptcm_pkg::FILL_FRAC_BITS_DEF,
   parameter int COUNTER_WIDTH = ptcm_pkg::COUNTER_WIDTH_DEF
) (
   input logic clock,
   input logic reset,
   input logic job_valid,
   output logic job_ready,
   input ptcm_pkg::job_type job,
   input logic [ptcm_pkg::IVL_W-1:0] interval,
   input logic [15:0] capacity,
   input logic [15:0] burst_limit,
   input logic [31:0] lateness_limit,
   ptcm_rsp_if.source rsp
);
   import ptcm_pkg::*;
   localparam int QW = 33; // quotient bits kept, one for saturation
   localparam int NB = 63 + FILL_FRAC_BITS; // dividend bits
   localparam int CB = $clog2(NB + 1);
   localparam logic [COUNTER_WIDTH-1:0] CMAX = '1;

   typedef enum logic [2:0] {IDLE, DIV, MUL, LATE, DONE} st_type;
   st_type st_ff;

   logic [31:0] base_ff, ext_ff;
   logic [63:0] origin_ff, prev_ff, worst_ff, arr_ff;
   logic [32:0] fill_ff;
   logic [31:0] peak_ff;
   logic [COUNTER_WIDTH-1:0] ovf_ff, late_ff, pkt_ff;
   logic [15:0] run_ff, lrun_ff;
   logic old_ff;
   logic signed [63:0] lat_ff;
   logic [IVL_W-1:0] ivl_ff;
   logic [NB-1:0] num_ff;
   logic [IVL_W:0] rem_ff;
   logic [QW-1:0] quo_ff;
   logic qsat_ff;
   logic [CB-1:0] cnt_ff;
   logic [63:0] prod_ff;
   logic out_v_ff;
   rsp_type out_ff;

   logic [IVL_W:0] rem_sh;
   logic [IVL_W:0] rem_sub;
   logic [63:0] el;
   logic close;
   logic [15:0] run_nx, lrun_nx;
   logic [32:0] drain, fill_nx;
   logic [31:0] fill_sat;
   logic signed [64:0] d65, lat65;
   logic signed [63:0] lat_nx;
   logic ovf_hit;

   function automatic logic [31:0] out32(input logic [COUNTER_WIDTH-1:0] c);
      logic [63:0] w;
      w = 64'(c);
      return (w > 64'hFFFFFFFF) ? 32'hFFFFFFFF : w[31:0];
   endfunction

   assign job_ready = st_ff == IDLE && !out_v_ff;
   assign rsp.valid = out_v_ff;
   assign rsp.payload = out_ff;

   always_comb begin
      rem_sh = {rem_ff[IVL_W-1:0], num_ff[NB-1]};
      rem_sub = rem_sh - {1'b0, ivl_ff};
      el = arr_ff - prev_ff;
      close = $signed(el) < $signed({34'd0, ivl_ff});
      run_nx = close ? ((run_ff != 16'hFFFF) ? run_ff + 16'd1 : run_ff) : 16'd1;
      lrun_nx = (close && run_nx > lrun_ff) ? run_nx : lrun_ff;
      drain = (qsat_ff || quo_ff[QW-1]) ? 33'h100000000 : {1'b0, quo_ff[31:0]};
      fill_nx = ((fill_ff > drain) ? fill_ff - drain : 33'd0) + (33'd1 << FILL_FRAC_BITS);
      fill_sat = fill_nx[32] ? 32'hFFFFFFFF : fill_nx[31:0];
      ovf_hit = {16'd0, fill_sat} > (48'(capacity) << FILL_FRAC_BITS);
      d65 = $signed({arr_ff[63], arr_ff}) - $signed({origin_ff[63], origin_ff});
      lat65 = d65 - $signed({1'b0, prod_ff});
      if (lat65 < -$signed(65'h1_0000_0000_0000_0000 >> 1)) lat_nx = 64'sh8000000000000000;
      else if (lat65 > $signed(65'h0_7FFF_FFFF_FFFF_FFFF)) lat_nx = 64'sh7FFFFFFFFFFFFFFF;
      else lat_nx = lat65[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= IDLE;
         out_v_ff <= 1'b0;
         base_ff <= '0;
         origin_ff <= '0;
         prev_ff <= '0;
         worst_ff <= '0;
         fill_ff <= '0;
         peak_ff <= '0;
         ovf_ff <= '0;
         late_ff <= '0;
         pkt_ff <= '0;
         run_ff <= '0;
         lrun_ff <= '0;
      end else begin
         if (rsp.valid && rsp.ready) out_v_ff <= 1'b0;
         case (st_ff)
            IDLE: begin
               if (job_valid && job_ready) begin
                  pkt_ff <= (pkt_ff != CMAX) ? pkt_ff + 1'b1 : pkt_ff;
                  arr_ff <= {1'b0, job.arrival};
                  ext_ff <= job.ext;
                  old_ff <= job.old;
                  ivl_ff <= (interval == '0) ? IVL_W'(1) : interval;
                  lat_ff <= '0;
                  if (job.first) begin
                     base_ff <= job.ext;
                     origin_ff <= {1'b0, job.arrival};
                     prev_ff <= {1'b0, job.arrival};
                     fill_ff <= 33'd1 << FILL_FRAC_BITS;
                     peak_ff <= 32'd1 << FILL_FRAC_BITS;
                     run_ff <= 16'd1;
                     lrun_ff <= 16'd1;
                     st_ff <= DONE;
                  end else if (job.old) begin
                     st_ff <= LATE;
                  end else begin
                     st_ff <= MUL;
                  end
               end
            end
            MUL: begin
               prod_ff <= 64'(ext_ff - base_ff) * 64'(ivl_ff);
               num_ff <= ($signed(el) > 0) ? {el[62:0], {FILL_FRAC_BITS{1'b0}}} : '0;
               rem_ff <= '0;
               quo_ff <= '0;
               qsat_ff <= 1'b0;
               cnt_ff <= CB'(NB);
               st_ff <= DIV;
            end
            DIV: begin
               num_ff <= num_ff << 1;
               qsat_ff <= qsat_ff | quo_ff[QW-1];
               if (rem_sh >= {1'b0, ivl_ff}) begin
                  rem_ff <= rem_sub;
                  quo_ff <= {quo_ff[QW-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  quo_ff <= {quo_ff[QW-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == CB'(1)) st_ff <= LATE;
            end
            LATE: begin
               run_ff <= run_nx;
               lrun_ff <= lrun_nx;
               prev_ff <= arr_ff;
               if (!old_ff) begin
                  fill_ff <= {1'b0, fill_sat};
                  if (fill_sat > peak_ff) peak_ff <= fill_sat;
                  if (ovf_hit && ovf_ff != CMAX) ovf_ff <= ovf_ff + 1'b1;
                  lat_ff <= lat_nx;
                  if (lat_nx > 0) begin
                     if (late_ff != CMAX) late_ff <= late_ff + 1'b1;
                     if (lat_nx > $signed(worst_ff)) worst_ff <= lat_nx;
                  end
               end
               st_ff <= DONE;
            end
            DONE: begin
               out_ff.old_or_duplicate <= old_ff;
               out_ff.buffer_fill <= fill_ff[31:0];
               out_ff.peak_buffer_fill <= peak_ff;
               out_ff.overflow_count <= out32(ovf_ff);
               out_ff.burst_length <= run_ff;
               out_ff.longest_burst <= lrun_ff;
               out_ff.packet_lateness_ns <= lat_ff;
               out_ff.worst_lateness_ns <= worst_ff[62:0];
               out_ff.late_packets <= out32(late_ff);
               out_ff.packet_count <= out32(pkt_ff);
               out_ff.compliant <= ovf_ff == '0 && lrun_ff <= burst_limit
                  && worst_ff <= {32'd0, lateness_limit};
               out_v_ff <= 1'b1;
               st_ff <= IDLE;
            end
            default: st_ff <= IDLE;
         endcase
      end
   end

   `include "packet_timing_compliance_monitor_top_macros.svh"
   `PTCM_ASSERT(a_one_rsp, clock, reset, st_ff == DONE |=> out_v_ff, "no response")
   `PTCM_ASSERT(a_peak, clock, reset, 1'b1 |-> {1'b0, peak_ff} >= fill_ff, "peak below fill")
   `PTCM_ASSERT(a_busy, clock, reset, st_ff != IDLE |-> !job_ready, "ready while busy")
endmodule

>>> sv/packet_timing_compliance_monitor_top.sv
// path from request acceptance to response valid: queue, then back-end states DONE
//    (first request), LATE, DONE (old) or MUL, DIV, LATE, DONE (newer), with the
//    one-bit-a-cycle restoring divider of elapsed time by the packet interval in DIV;
//    the back end takes no new request until its last response has been accepted
// reset: synchronous, clears all statistics and restores register defaults
module packet_timing_compliance_monitor_top #(
   parameter int FILL_FRAC_BITS = ptcm_pkg::FILL_FRAC_BITS_DEF,
   parameter int COUNTER_WIDTH = ptcm_pkg::COUNTER_WIDTH_DEF
) (
   input logic clock,
   input logic reset,
   ptcm_req_if.sink req,
   ptcm_rsp_if.source rsp,
   input logic csr_write_enable,
   input logic [ptcm_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [ptcm_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import ptcm_pkg::*;
   logic [IVL_W-1:0] ivl_ff;
   logic [15:0] cap_ff, burst_ff;
   logic [31:0] late_ff;
   logic fj_valid, fj_ready, bj_valid, bj_ready;
   job_type fj, bj;

   always_ff @(posedge clock) begin
      if (reset) begin
         ivl_ff <= RST_INTERVAL;
         cap_ff <= RST_CAPACITY;
         burst_ff <= RST_BURST;
         late_ff <= RST_LATENESS;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_INTERVAL: ivl_ff <= csr_write_data[IVL_W-1:0];
            CSR_CAPACITY: cap_ff <= csr_write_data[15:0];
            CSR_BURST: burst_ff <= csr_write_data[15:0];
            CSR_LATENESS: late_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   ptcm_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
   );

   ptcm_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(fj_valid), .in_ready(fj_ready), .in_job(fj),
      .out_valid(bj_valid), .out_ready(bj_ready), .out_job(bj)
   );

   ptcm_back #(.FILL_FRAC_BITS(FILL_FRAC_BITS), .COUNTER_WIDTH(COUNTER_WIDTH)) u_back (
      .clock(clock), .reset(reset),
      .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
      .interval(ivl_ff), .capacity(cap_ff), .burst_limit(burst_ff),
      .lateness_limit(late_ff), .rsp(rsp)
   );
endmodule
